FILE: rtl/xtvd_pkg.sv
`default_nettype none

package xtvd_pkg;

  // block geometry
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned KEY_IDX_W   = 2;
  localparam int unsigned ROUND_COUNT = 64;
  localparam int unsigned ROUND_IDX_W = 7;

  // round constant added to the running sum once per round
  localparam logic [WORD_W-1:0] ROUND_DELTA = 32'h61C8_8747;

  // configuration register indexes
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_ZERO  = 2'd0;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_ONE   = 2'd1;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_TWO   = 2'd2;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_THREE = 2'd3;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [KEY_WORDS-1:0] key_t;

  // two-word data block moving down the pipeline
  typedef struct packed {
    word_t w0;
    word_t w1;
  } blk_t;

  // shift-and-add mixing of one word
  function automatic word_t mix_word(input word_t w);
    return w + ((w >> 5) ^ (w << 4));
  endfunction

  // running sum at the start of round r: -(delta * (rounds - r)) mod 2^32
  function automatic word_t round_sum(input logic [ROUND_IDX_W-1:0] r);
    word_t left;
    left = WORD_W'(ROUND_COUNT) - WORD_W'(r);
    return word_t'(0) - word_t'(ROUND_DELTA * left);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/xtea_variant_block_decrypt_top.sv
// Modified XTEA block decryption, one 64-bit block per transfer.
// Input channel: in_valid / in_stall with the two ciphertext words; a
// transfer happens on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall with the two plaintext words.
// Key: four 32-bit words written through cfg_wr_en / cfg_index / cfg_wdata,
// one word per write; write only while no block is in flight.
// Each round is two register stages (one per word update), so a block
// passes through 2 * 64 = 128 stages, the mid and out registers of each
// round in turn, before out_valid rises for it. One block is taken every
// cycle while the result channel is not stalled, so throughput is one
// block per cycle.
// A stall of the result channel while out_valid is high freezes the whole
// pipeline, and in_stall rises in the same cycle; nothing is dropped or
// repeated. Empty stages never hold up the input.
// Reset (synchronous, active low) clears all valid bits and the key words.
`default_nettype none

module xtea_variant_block_decrypt_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [xtvd_pkg::WORD_W-1:0]       in_cipher_first,
  input  wire logic [xtvd_pkg::WORD_W-1:0]       in_cipher_second,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [xtvd_pkg::WORD_W-1:0]            out_plain_first,
  output logic [xtvd_pkg::WORD_W-1:0]            out_plain_second,
  input  wire logic                              cfg_wr_en,
  input  wire logic [xtvd_pkg::KEY_IDX_W-1:0]    cfg_index,
  input  wire logic [xtvd_pkg::WORD_W-1:0]       cfg_wdata
);

  xtvd_pkg::key_t keys_r;
  logic           pipe_en;
  logic           stage_vld [0:xtvd_pkg::ROUND_COUNT];
  xtvd_pkg::blk_t stage_blk [0:xtvd_pkg::ROUND_COUNT];

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        xtvd_pkg::KEY_IDX_ZERO:  keys_r[0] <= cfg_wdata;
        xtvd_pkg::KEY_IDX_ONE:   keys_r[1] <= cfg_wdata;
        xtvd_pkg::KEY_IDX_TWO:   keys_r[2] <= cfg_wdata;
        xtvd_pkg::KEY_IDX_THREE: keys_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished result is held off
  assign pipe_en  = !(stage_vld[xtvd_pkg::ROUND_COUNT] && out_stall);
  assign in_stall = !pipe_en;

  assign stage_vld[0]    = in_valid;
  assign stage_blk[0].w0 = in_cipher_first;
  assign stage_blk[0].w1 = in_cipher_second;

  // one round unit per round, sum fixed by position
  for (genvar r = 0; r < xtvd_pkg::ROUND_COUNT; r++) begin : g_round
    xtvd_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pipe_en),
      .keys    (keys_r),
      .sum_in  (xtvd_pkg::round_sum(xtvd_pkg::ROUND_IDX_W'(r))),
      .in_vld  (stage_vld[r]),
      .in_blk  (stage_blk[r]),
      .out_vld (stage_vld[r+1]),
      .out_blk (stage_blk[r+1])
    );
  end

  assign out_valid        = stage_vld[xtvd_pkg::ROUND_COUNT];
  assign out_plain_first  = stage_blk[xtvd_pkg::ROUND_COUNT].w0;
  assign out_plain_second = stage_blk[xtvd_pkg::ROUND_COUNT].w1;

endmodule

`default_nettype wire

FILE: rtl/xtvd_round.sv
`default_nettype none

module xtvd_round (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire xtvd_pkg::key_t   keys,
  input  wire xtvd_pkg::word_t  sum_in,
  input  wire logic             in_vld,
  input  wire xtvd_pkg::blk_t   in_blk,
  output logic                  out_vld,
  output xtvd_pkg::blk_t        out_blk
);

  logic            mid_vld_r;
  xtvd_pkg::blk_t  mid_blk_r;
  xtvd_pkg::blk_t  mid_blk_nxt;
  logic            out_vld_r;
  xtvd_pkg::blk_t  out_blk_r;
  xtvd_pkg::blk_t  out_blk_nxt;
  xtvd_pkg::word_t sum_hi;

  // first half: update the second word with the incoming sum
  always_comb begin
    mid_blk_nxt    = in_blk;
    mid_blk_nxt.w1 = in_blk.w1 - (in_blk.w0 ^ (keys[sum_in[12:11]] + sum_in)
                     ^ xtvd_pkg::mix_word(in_blk.w0));
  end

  // second half: advance the sum, then update the first word
  assign sum_hi = sum_in + xtvd_pkg::ROUND_DELTA;

  always_comb begin
    out_blk_nxt    = mid_blk_r;
    out_blk_nxt.w0 = mid_blk_r.w0 - (mid_blk_r.w1 ^ (keys[sum_hi[1:0]] + sum_hi)
                     ^ xtvd_pkg::mix_word(mid_blk_r.w1));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      mid_vld_r <= in_vld;
      out_vld_r <= mid_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      mid_blk_r <= mid_blk_nxt;
      out_blk_r <= out_blk_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_blk = out_blk_r;

endmodule

`default_nettype wire
